### rtl/wrp_pkg.sv
package wrp_pkg;

  localparam int VertexCount = 10;
  localparam int SegCount    = 13;
  localparam int IdxW        = $clog2(VertexCount);
  localparam int SegW        = $clog2(SegCount + 1);
  localparam int PcW         = 5;
  localparam int CenterW     = 10;
  localparam int CoordW      = 32;
  localparam int PixW        = 16;
  localparam int ScaleW      = 16;
  localparam int ConstW      = 26;
  localparam int ProdW       = CoordW + ConstW;
  localparam int AccW        = 64;
  localparam int OffW        = 18;
  localparam int CfgIdxW     = 1;

  // Rotation sines and cosines as Q1.30 values; narrowed to FRAC_BITS at elaboration.
  localparam longint SinBQ30 = 64'sd10737239;
  localparam longint CosBQ30 = 64'sd1073688137;
  localparam longint SinCQ30 = 64'sd32207423;
  localparam longint CosCQ30 = 64'sd1073258676;

  localparam logic [CfgIdxW-1:0] RegCenterX = 1'd0;
  localparam logic [CfgIdxW-1:0] RegCenterY = 1'd1;

  typedef logic [IdxW-1:0] vidx_t;
  typedef logic [SegW-1:0] seg_t;
  typedef logic [PcW-1:0]  upc_t;

  // Microprogram addresses.
  localparam upc_t PcIdle    = 5'd0;
  localparam upc_t PcProj0   = 5'd1;
  localparam upc_t PcProj1   = 5'd2;
  localparam upc_t PcProj2   = 5'd3;
  localparam upc_t PcProj3   = 5'd4;
  localparam upc_t PcSeg0    = 5'd5;
  localparam upc_t PcSeg1    = 5'd6;
  localparam upc_t PcRot0    = 5'd7;
  localparam upc_t PcRot1    = 5'd8;
  localparam upc_t PcRot2    = 5'd9;
  localparam upc_t PcRot3    = 5'd10;
  localparam upc_t PcRot4    = 5'd11;
  localparam upc_t PcRot5    = 5'd12;
  localparam upc_t PcRot6    = 5'd13;
  localparam upc_t PcRot7    = 5'd14;
  localparam upc_t PcRot8    = 5'd15;
  localparam upc_t PcRot9    = 5'd16;
  localparam upc_t PcRot10   = 5'd17;
  localparam upc_t PcReturn  = 5'd18;

  typedef enum logic [1:0] {HOLD_NONE, HOLD_IN, HOLD_OUT} hold_t;
  typedef enum logic [1:0] {J_NEXT, J_GOTO, J_IDX_LOOP, J_SEG_LOOP} jump_t;
  typedef enum logic [1:0] {OPA_VX, OPA_VY, OPA_VZ, OPA_Z1} opa_t;
  typedef enum logic [2:0] {
    OPB_SCALE, OPB_COS_B, OPB_SIN_B, OPB_NSIN_B, OPB_COS_C, OPB_SIN_C, OPB_NSIN_C
  } opb_t;
  typedef enum logic [2:0] {ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_OFFX, ACC_OFFY} acc_op_t;
  typedef enum logic [3:0] {
    WR_NONE, WR_SX, WR_SY, WR_Z1, WR_VX, WR_VY, WR_VZ, WR_START, WR_OUT
  } wr_t;

  typedef struct packed {
    hold_t   hold_on;
    jump_t   jmp;
    upc_t    target;
    opa_t    opa;
    opb_t    opb;
    acc_op_t acc_op;
    wr_t     wr;
    logic    take_in;
    logic    idx_step;
  } ctrl_t;

  typedef struct packed {
    logic idx_last;
    logic seg_last;
    logic out_free;
  } status_t;

  localparam ctrl_t CtrlNop = '{
    hold_on: HOLD_NONE, jmp: J_NEXT, target: PcIdle, opa: OPA_VX, opb: OPB_SCALE,
    acc_op: ACC_HOLD, wr: WR_NONE, take_in: 1'b0, idx_step: 1'b0
  };

  // Cube corners in whole units.
  function automatic logic signed [7:0] corner_x(vidx_t i);
    logic signed [7:0] v;
    case (i)
      4'd1, 4'd2, 4'd6, 4'd7: v = 8'sd70;
      default:                v = 8'sd20;
    endcase
    return v;
  endfunction

  function automatic logic signed [7:0] corner_y(vidx_t i);
    logic signed [7:0] v;
    case (i)
      4'd2, 4'd3, 4'd7, 4'd8: v = 8'sd70;
      default:                v = 8'sd20;
    endcase
    return v;
  endfunction

  function automatic logic signed [7:0] corner_z(vidx_t i);
    logic signed [7:0] v;
    case (i)
      4'd5, 4'd6, 4'd7, 4'd8, 4'd9: v = -8'sd20;
      default:                      v = 8'sd20;
    endcase
    return v;
  endfunction

  // Edge list: the chain 0 to 9, then edges i to i+5 for i = 0 to 3.
  function automatic vidx_t seg_start(seg_t k);
    vidx_t v;
    if (k < seg_t'(VertexCount - 1)) v = vidx_t'(k);
    else                             v = vidx_t'(k - seg_t'(VertexCount - 1));
    return v;
  endfunction

  function automatic vidx_t seg_end(seg_t k);
    vidx_t v;
    if (k < seg_t'(VertexCount - 1)) v = vidx_t'(k + seg_t'(1));
    else                             v = vidx_t'(k - seg_t'(4));
    return v;
  endfunction

endpackage

### rtl/wireframe_rotate_project.sv
// Wireframe rotate-and-project engine. The block holds the ten vertices of a
// wireframe cube as signed fixed-point coordinates with FRAC_BITS fraction
// bits, starting from the cube corners after reset. Each input transaction
// is one frame tick carrying scale (unsigned Q8.8), pan_x and pan_y. The
// block projects every vertex to the screen, emits 13 line segments as
// output transactions (the chain 0 to 9, then edges i to i+5 for i = 0 to 3,
// the last one flagged by last_segment), and then rotates every vertex
// in place about Y and then about X by small fixed angles. Screen values are
// truncated toward zero and saturated to 16 bits; rotated coordinates are
// rounded half up and saturated to 32 bits. A frame steps in order through
// taking the transaction, projecting each vertex, reading the screen table
// for each segment (waiting while the output side stalls), rotating each
// vertex in place and returning to idle. The single shared 32x26 multiplier
// is driven by a microprogrammed sequencer one product per cycle. The next
// frame is taken only after the rotation pass has finished, so in_stall is
// high for the whole frame. center_x and center_y are written through wr_en,
// wr_index and wr_data and should be changed only while the block is idle.
module wireframe_rotate_project #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 wr_en,
  input  logic [wrp_pkg::CfgIdxW-1:0]          wr_index,
  input  logic [wrp_pkg::CenterW-1:0]          wr_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [wrp_pkg::ScaleW-1:0]           scale,
  input  logic signed [wrp_pkg::PixW-1:0]      pan_x,
  input  logic signed [wrp_pkg::PixW-1:0]      pan_y,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [wrp_pkg::PixW-1:0]      start_x,
  output logic signed [wrp_pkg::PixW-1:0]      start_y,
  output logic signed [wrp_pkg::PixW-1:0]      end_x,
  output logic signed [wrp_pkg::PixW-1:0]      end_y,
  output logic                                 last_segment
);

  wrp_pkg::ctrl_t   ctrl;
  wrp_pkg::status_t status;
  logic             idle;

  // The sequencer steps through the control store; its idle step is the only
  // one that accepts a frame transaction.
  wrp_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .ctrl     (ctrl),
    .idle     (idle)
  );

  assign in_stall = !idle;

  // The datapath holds the vertex and screen tables, the shared multiplier and
  // accumulator, the configuration registers and the output register.
  wrp_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .status       (status),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .scale        (scale),
    .pan_x        (pan_x),
    .pan_y        (pan_y),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .start_x      (start_x),
    .start_y      (start_y),
    .end_x        (end_x),
    .end_y        (end_y),
    .last_segment (last_segment)
  );

endmodule

### rtl/wrp_ucode_rom.sv
module wrp_ucode_rom (
  input  wrp_pkg::upc_t  pc,
  output wrp_pkg::ctrl_t word
);

  always_comb begin
    word = wrp_pkg::CtrlNop;
    unique case (pc)
      wrp_pkg::PcIdle: begin
        word.hold_on = wrp_pkg::HOLD_IN;
        word.take_in = 1'b1;
      end
      wrp_pkg::PcProj0: begin
        word.opa = wrp_pkg::OPA_VX;
        word.opb = wrp_pkg::OPB_SCALE;
      end
      wrp_pkg::PcProj1: begin
        word.acc_op = wrp_pkg::ACC_OFFX;
        word.opa    = wrp_pkg::OPA_VY;
        word.opb    = wrp_pkg::OPB_SCALE;
      end
      wrp_pkg::PcProj2: begin
        word.wr     = wrp_pkg::WR_SX;
        word.acc_op = wrp_pkg::ACC_OFFY;
      end
      wrp_pkg::PcProj3: begin
        word.wr       = wrp_pkg::WR_SY;
        word.idx_step = 1'b1;
        word.jmp      = wrp_pkg::J_IDX_LOOP;
        word.target   = wrp_pkg::PcProj0;
      end
      wrp_pkg::PcSeg0: begin
        word.wr = wrp_pkg::WR_START;
      end
      wrp_pkg::PcSeg1: begin
        word.hold_on = wrp_pkg::HOLD_OUT;
        word.wr      = wrp_pkg::WR_OUT;
        word.jmp     = wrp_pkg::J_SEG_LOOP;
        word.target  = wrp_pkg::PcSeg0;
      end
      wrp_pkg::PcRot0: begin
        word.opa = wrp_pkg::OPA_VZ;
        word.opb = wrp_pkg::OPB_COS_B;
      end
      wrp_pkg::PcRot1: begin
        word.acc_op = wrp_pkg::ACC_LOAD;
        word.opa    = wrp_pkg::OPA_VX;
        word.opb    = wrp_pkg::OPB_NSIN_B;
      end
      wrp_pkg::PcRot2: begin
        word.acc_op = wrp_pkg::ACC_ADD;
        word.opa    = wrp_pkg::OPA_VZ;
        word.opb    = wrp_pkg::OPB_SIN_B;
      end
      wrp_pkg::PcRot3: begin
        word.wr     = wrp_pkg::WR_Z1;
        word.acc_op = wrp_pkg::ACC_LOAD;
        word.opa    = wrp_pkg::OPA_VX;
        word.opb    = wrp_pkg::OPB_COS_B;
      end
      wrp_pkg::PcRot4: begin
        word.acc_op = wrp_pkg::ACC_ADD;
      end
      wrp_pkg::PcRot5: begin
        word.wr  = wrp_pkg::WR_VX;
        word.opa = wrp_pkg::OPA_VY;
        word.opb = wrp_pkg::OPB_COS_C;
      end
      wrp_pkg::PcRot6: begin
        word.acc_op = wrp_pkg::ACC_LOAD;
        word.opa    = wrp_pkg::OPA_Z1;
        word.opb    = wrp_pkg::OPB_NSIN_C;
      end
      wrp_pkg::PcRot7: begin
        word.acc_op = wrp_pkg::ACC_ADD;
        word.opa    = wrp_pkg::OPA_VY;
        word.opb    = wrp_pkg::OPB_SIN_C;
      end
      wrp_pkg::PcRot8: begin
        word.wr     = wrp_pkg::WR_VY;
        word.acc_op = wrp_pkg::ACC_LOAD;
        word.opa    = wrp_pkg::OPA_Z1;
        word.opb    = wrp_pkg::OPB_COS_C;
      end
      wrp_pkg::PcRot9: begin
        word.acc_op = wrp_pkg::ACC_ADD;
      end
      wrp_pkg::PcRot10: begin
        word.wr       = wrp_pkg::WR_VZ;
        word.idx_step = 1'b1;
        word.jmp      = wrp_pkg::J_IDX_LOOP;
        word.target   = wrp_pkg::PcRot0;
      end
      wrp_pkg::PcReturn: begin
        word.jmp    = wrp_pkg::J_GOTO;
        word.target = wrp_pkg::PcIdle;
      end
      default: begin
        word.jmp    = wrp_pkg::J_GOTO;
        word.target = wrp_pkg::PcIdle;
      end
    endcase
  end

endmodule

### rtl/wrp_sequencer.sv
module wrp_sequencer (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  wrp_pkg::status_t status,
  output wrp_pkg::ctrl_t   ctrl,
  output logic             idle
);

  wrp_pkg::upc_t  pc;
  wrp_pkg::upc_t  pc_next;
  wrp_pkg::ctrl_t word;
  logic           go;

  wrp_ucode_rom u_rom (
    .pc   (pc),
    .word (word)
  );

  // A step that waits on a handshake does nothing until its condition holds.
  always_comb begin
    unique case (word.hold_on)
      wrp_pkg::HOLD_IN:  go = in_valid;
      wrp_pkg::HOLD_OUT: go = status.out_free;
      default:           go = 1'b1;
    endcase
  end

  always_comb begin
    ctrl = word;
    if (!go) begin
      ctrl.wr       = wrp_pkg::WR_NONE;
      ctrl.acc_op   = wrp_pkg::ACC_HOLD;
      ctrl.take_in  = 1'b0;
      ctrl.idx_step = 1'b0;
    end
  end

  always_comb begin
    pc_next = pc + 1'b1;
    if (!go) begin
      pc_next = pc;
    end else begin
      unique case (word.jmp)
        wrp_pkg::J_GOTO:     pc_next = word.target;
        wrp_pkg::J_IDX_LOOP: if (!status.idx_last) pc_next = word.target;
        wrp_pkg::J_SEG_LOOP: if (!status.seg_last) pc_next = word.target;
        default:             pc_next = pc + 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= wrp_pkg::PcIdle;
    end else begin
      pc <= pc_next;
    end
  end

  assign idle = (pc == wrp_pkg::PcIdle);

endmodule

### rtl/wrp_datapath.sv
module wrp_datapath #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  wrp_pkg::ctrl_t                       ctrl,
  output wrp_pkg::status_t                     status,
  input  logic                                 wr_en,
  input  logic [wrp_pkg::CfgIdxW-1:0]          wr_index,
  input  logic [wrp_pkg::CenterW-1:0]          wr_data,
  input  logic [wrp_pkg::ScaleW-1:0]           scale,
  input  logic signed [wrp_pkg::PixW-1:0]      pan_x,
  input  logic signed [wrp_pkg::PixW-1:0]      pan_y,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [wrp_pkg::PixW-1:0]      start_x,
  output logic signed [wrp_pkg::PixW-1:0]      start_y,
  output logic signed [wrp_pkg::PixW-1:0]      end_x,
  output logic signed [wrp_pkg::PixW-1:0]      end_y,
  output logic                                 last_segment
);

  localparam int VC        = wrp_pkg::VertexCount;
  localparam int CW        = wrp_pkg::CoordW;
  localparam int PW        = wrp_pkg::PixW;
  localparam int KW        = wrp_pkg::ConstW;
  localparam int AW        = wrp_pkg::AccW;
  localparam int ProjShift = FRAC_BITS + 8;

  localparam logic signed [KW-1:0] SinB = KW'((wrp_pkg::SinBQ30 +
      (longint'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS));
  localparam logic signed [KW-1:0] CosB = KW'((wrp_pkg::CosBQ30 +
      (longint'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS));
  localparam logic signed [KW-1:0] SinC = KW'((wrp_pkg::SinCQ30 +
      (longint'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS));
  localparam logic signed [KW-1:0] CosC = KW'((wrp_pkg::CosCQ30 +
      (longint'(1) <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS));
  localparam logic signed [KW-1:0] NSinB = -SinB;
  localparam logic signed [KW-1:0] NSinC = -SinC;

  localparam logic signed [AW-1:0] ProjBias  = (64'sd1 <<< ProjShift) - 64'sd1;
  localparam logic signed [AW-1:0] RoundHalf = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [AW-1:0] PixMax    = 64'sd32767;
  localparam logic signed [AW-1:0] PixMin    = -64'sd32768;
  localparam logic signed [AW-1:0] CoordMax  = 64'sd2147483647;
  localparam logic signed [AW-1:0] CoordMin  = -64'sd2147483648;

  logic signed [CW-1:0] vx [VC];
  logic signed [CW-1:0] vy [VC];
  logic signed [CW-1:0] vz [VC];
  logic signed [PW-1:0] sx [VC];
  logic signed [PW-1:0] sy [VC];

  wrp_pkg::vidx_t idx;
  wrp_pkg::seg_t  seg;
  wrp_pkg::vidx_t rd_addr;

  logic [wrp_pkg::CenterW-1:0]     center_x;
  logic [wrp_pkg::CenterW-1:0]     center_y;
  logic [wrp_pkg::ScaleW-1:0]      scale_q;
  logic signed [PW-1:0]            pan_x_q;
  logic signed [PW-1:0]            pan_y_q;
  logic signed [PW-1:0]            first_x;
  logic signed [PW-1:0]            first_y;

  logic signed [CW-1:0]            z1;
  logic signed [CW-1:0]            opa;
  logic signed [KW-1:0]            opb;
  logic signed [wrp_pkg::ProdW-1:0] mul_full;
  logic signed [wrp_pkg::ProdW-1:0] prod;
  logic signed [AW-1:0]            acc;

  logic signed [wrp_pkg::OffW-1:0] off_x;
  logic signed [wrp_pkg::OffW-1:0] off_y;
  logic signed [AW-1:0]            off_x_wide;
  logic signed [AW-1:0]            off_y_wide;
  logic signed [AW-1:0]            tr_sum;
  logic signed [AW-1:0]            tr_q;
  logic signed [PW-1:0]            pix;
  logic signed [AW-1:0]            rn_q;
  logic signed [CW-1:0]            rot;

  always_comb begin
    unique case (ctrl.opa)
      wrp_pkg::OPA_VX: opa = vx[idx];
      wrp_pkg::OPA_VY: opa = vy[idx];
      wrp_pkg::OPA_VZ: opa = vz[idx];
      wrp_pkg::OPA_Z1: opa = z1;
      default:         opa = z1;
    endcase
  end

  always_comb begin
    unique case (ctrl.opb)
      wrp_pkg::OPB_SCALE:  opb = KW'(signed'({1'b0, scale_q}));
      wrp_pkg::OPB_COS_B:  opb = CosB;
      wrp_pkg::OPB_SIN_B:  opb = SinB;
      wrp_pkg::OPB_NSIN_B: opb = NSinB;
      wrp_pkg::OPB_COS_C:  opb = CosC;
      wrp_pkg::OPB_SIN_C:  opb = SinC;
      wrp_pkg::OPB_NSIN_C: opb = NSinC;
      default:             opb = KW'(signed'({1'b0, scale_q}));
    endcase
  end

  assign mul_full = opa * opb;

  // Screen offsets: center plus pan for x, center minus pan for y.
  assign off_x = wrp_pkg::OffW'(signed'({1'b0, center_x})) + wrp_pkg::OffW'(pan_x_q);
  assign off_y = wrp_pkg::OffW'(signed'({1'b0, center_y})) - wrp_pkg::OffW'(pan_y_q);
  assign off_x_wide = AW'(off_x) <<< ProjShift;
  assign off_y_wide = AW'(off_y) <<< ProjShift;

  // Projection result: divide by the scale unit rounding toward zero, then saturate.
  assign tr_sum = acc[AW-1] ? acc + ProjBias : acc;
  assign tr_q   = tr_sum >>> ProjShift;
  always_comb begin
    if (tr_q > PixMax)      pix = PW'(PixMax);
    else if (tr_q < PixMin) pix = PW'(PixMin);
    else                    pix = tr_q[PW-1:0];
  end

  // Rotation result: round half up at the fraction point, then saturate.
  assign rn_q = (acc + RoundHalf) >>> FRAC_BITS;
  always_comb begin
    if (rn_q > CoordMax)      rot = CW'(CoordMax);
    else if (rn_q < CoordMin) rot = CW'(CoordMin);
    else                      rot = rn_q[CW-1:0];
  end

  always_comb begin
    if (ctrl.wr == wrp_pkg::WR_START) rd_addr = wrp_pkg::seg_start(seg);
    else                              rd_addr = wrp_pkg::seg_end(seg);
  end

  always_ff @(posedge clk) begin
    prod <= mul_full;
    unique case (ctrl.acc_op)
      wrp_pkg::ACC_LOAD: acc <= AW'(prod);
      wrp_pkg::ACC_ADD:  acc <= acc + AW'(prod);
      wrp_pkg::ACC_OFFX: acc <= off_x_wide + AW'(prod);
      wrp_pkg::ACC_OFFY: acc <= off_y_wide - AW'(prod);
      default:           acc <= acc;
    endcase
    if (ctrl.take_in) begin
      scale_q <= scale;
      pan_x_q <= pan_x;
      pan_y_q <= pan_y;
    end
    case (ctrl.wr)
      wrp_pkg::WR_SX:    sx[idx] <= pix;
      wrp_pkg::WR_SY:    sy[idx] <= pix;
      wrp_pkg::WR_Z1:    z1 <= rot;
      wrp_pkg::WR_START: begin
        first_x <= sx[rd_addr];
        first_y <= sy[rd_addr];
      end
      wrp_pkg::WR_OUT: begin
        start_x      <= first_x;
        start_y      <= first_y;
        end_x        <= sx[rd_addr];
        end_y        <= sy[rd_addr];
        last_segment <= status.seg_last;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < VC; i++) begin
        vx[i] <= CW'(wrp_pkg::corner_x(wrp_pkg::vidx_t'(i))) <<< FRAC_BITS;
        vy[i] <= CW'(wrp_pkg::corner_y(wrp_pkg::vidx_t'(i))) <<< FRAC_BITS;
        vz[i] <= CW'(wrp_pkg::corner_z(wrp_pkg::vidx_t'(i))) <<< FRAC_BITS;
      end
    end else begin
      case (ctrl.wr)
        wrp_pkg::WR_VX: vx[idx] <= rot;
        wrp_pkg::WR_VY: vy[idx] <= rot;
        wrp_pkg::WR_VZ: vz[idx] <= rot;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      seg       <= '0;
      out_valid <= 1'b0;
      center_x  <= wrp_pkg::CenterW'(66);
      center_y  <= wrp_pkg::CenterW'(88);
    end else begin
      if (ctrl.take_in) begin
        idx <= '0;
      end else if (ctrl.idx_step) begin
        idx <= status.idx_last ? '0 : idx + 1'b1;
      end
      if (ctrl.take_in) begin
        seg <= '0;
      end else if (ctrl.wr == wrp_pkg::WR_OUT) begin
        seg <= seg + 1'b1;
      end
      if (ctrl.wr == wrp_pkg::WR_OUT) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (wr_en) begin
        case (wr_index)
          wrp_pkg::RegCenterX: center_x <= wr_data;
          wrp_pkg::RegCenterY: center_y <= wr_data;
          default: begin
          end
        endcase
      end
    end
  end

  assign status.idx_last = (idx == wrp_pkg::vidx_t'(VC - 1));
  assign status.seg_last = (seg == wrp_pkg::seg_t'(wrp_pkg::SegCount - 1));
  assign status.out_free = !out_valid || !out_stall;

endmodule
